// ===== design/pofm_pkg.sv =====
// ----------------------------------------------------------------------------
// pofm_pkg
// Shared types, codes, thresholds and functions of the pack overcurrent monitor.
// ----------------------------------------------------------------------------
package pofm_pkg;

  localparam int MS_COUNTER_WIDTH_DEF = 16;

  // commands
  localparam logic CMD_EVAL  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // operating modes
  localparam logic [1:0] MODE_IDLE      = 2'd0;
  localparam logic [1:0] MODE_DRIVE     = 2'd1;
  localparam logic [1:0] MODE_CHARGE    = 2'd2;
  localparam logic [1:0] MODE_PRECHARGE = 2'd3;

  // sensor status
  localparam logic [2:0] STAT_ADC_READ   = 3'd3;
  localparam logic [2:0] STAT_IMPLAUS    = 3'd4;
  localparam logic [2:0] STAT_SATURATION = 3'd5;
  localparam logic [2:0] STAT_MISMATCH   = 3'd6;

  // reason codes
  localparam logic [4:0] R_NONE       = 5'd0;
  localparam logic [4:0] R_NOT_READY  = 5'd1;
  localparam logic [4:0] R_ADC_READ   = 5'd2;
  localparam logic [4:0] R_IMPLAUS    = 5'd3;
  localparam logic [4:0] R_SATURATION = 5'd4;
  localparam logic [4:0] R_MISMATCH   = 5'd5;
  localparam logic [4:0] R_DIS_BASE   = 5'd6;
  localparam logic [4:0] R_CHG_BASE   = 5'd10;
  localparam logic [4:0] R_REG_BASE   = 5'd14;
  localparam logic [4:0] R_REG_UNEXP  = 5'd18;
  localparam logic [4:0] R_PRE_BASE   = 5'd19;

  // register indexes
  localparam logic [2:0] REG_REGEN_EN  = 3'd0;
  localparam logic [2:0] REG_SENSOR_MS = 3'd1;
  localparam logic [2:0] REG_SLOW_MS   = 3'd2;
  localparam logic [2:0] REG_FAST_MS   = 3'd3;
  localparam logic [2:0] REG_PRE_SLOW  = 3'd4;
  localparam logic [2:0] REG_PRE_FAST  = 3'd5;

  // register reset values
  localparam logic [15:0] SENSOR_MS_RST = 16'd500;
  localparam logic [15:0] SLOW_MS_RST   = 16'd500;
  localparam logic [15:0] FAST_MS_RST   = 16'd100;
  localparam logic [15:0] PRE_SLOW_RST  = 16'd200;
  localparam logic [15:0] PRE_FAST_RST  = 16'd40;

  // thresholds, 10 mA units
  localparam logic [14:0] DIS_WARN = 15'd7000;
  localparam logic [14:0] DIS_TRIP = 15'd8500;
  localparam logic [14:0] DIS_FAST = 15'd12000;
  localparam logic [14:0] DIS_EXT  = 15'd24000;
  localparam logic [14:0] CHG_WARN = 15'd1050;
  localparam logic [14:0] CHG_TRIP = 15'd1200;
  localparam logic [14:0] CHG_FAST = 15'd1500;
  localparam logic [14:0] CHG_EXT  = 15'd3000;
  localparam logic [14:0] REG_WARN = 15'd2000;
  localparam logic [14:0] REG_TRIP = 15'd2500;
  localparam logic [14:0] REG_FAST = 15'd3000;
  localparam logic [14:0] REG_EXT  = 15'd5000;
  localparam logic [14:0] REG_UNEXP_LVL = 15'd500;
  localparam logic [14:0] PRE_WARN = 15'd80;
  localparam logic [14:0] PRE_TRIP = 15'd120;
  localparam logic [14:0] PRE_FAST = 15'd200;

  typedef enum logic [1:0] {
    LAD_DISCHARGE,
    LAD_CHARGE,
    LAD_REGEN,
    LAD_PRECHARGE
  } ladder_sel_t;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_WARN,
    KIND_TRIP
  } level_kind_t;

  typedef enum logic [2:0] {
    CONF_NOW,
    CONF_SLOW,
    CONF_FAST,
    CONF_PRE_SLOW,
    CONF_PRE_FAST
  } confirm_sel_t;

  typedef struct packed {
    level_kind_t  kind;
    logic [4:0]   code;
    logic [14:0]  thr;
    confirm_sel_t conf;
  } ladder_t;

  function automatic logic [4:0] sensor_code(logic [2:0] status);
    logic [4:0] c;
    unique case (status)
      STAT_ADC_READ:   c = R_ADC_READ;
      STAT_IMPLAUS:    c = R_IMPLAUS;
      STAT_SATURATION: c = R_SATURATION;
      STAT_MISMATCH:   c = R_MISMATCH;
      default:         c = R_NOT_READY;
    endcase
    return c;
  endfunction

  function automatic ladder_t run_ladder(logic [16:0] mag, ladder_sel_t sel,
                                         logic regen_en);
    ladder_t     r;
    logic [14:0] w;
    logic [14:0] t;
    logic [14:0] f;
    logic [14:0] x;
    logic [4:0]  base;
    logic        pre;
    r = '{kind: KIND_NONE, code: R_NONE, thr: 15'd0, conf: CONF_NOW};
    pre = 1'b0;
    unique case (sel)
      LAD_DISCHARGE: begin
        w = DIS_WARN; t = DIS_TRIP; f = DIS_FAST; x = DIS_EXT; base = R_DIS_BASE;
      end
      LAD_CHARGE: begin
        w = CHG_WARN; t = CHG_TRIP; f = CHG_FAST; x = CHG_EXT; base = R_CHG_BASE;
      end
      LAD_REGEN: begin
        w = REG_WARN; t = REG_TRIP; f = REG_FAST; x = REG_EXT; base = R_REG_BASE;
      end
      default: begin
        w = PRE_WARN; t = PRE_TRIP; f = PRE_FAST; x = 15'd0; base = R_PRE_BASE;
        pre = 1'b1;
      end
    endcase
    if (x != 15'd0 && mag >= {2'b00, x}) begin
      r = '{kind: KIND_TRIP, code: base + 5'd3, thr: x, conf: CONF_NOW};
    end else if (mag >= {2'b00, f}) begin
      r = '{kind: KIND_TRIP, code: base + 5'd2, thr: f,
            conf: pre ? CONF_PRE_FAST : CONF_FAST};
    end else if (mag >= {2'b00, t}) begin
      r = '{kind: KIND_TRIP, code: base + 5'd1, thr: t,
            conf: pre ? CONF_PRE_SLOW : CONF_SLOW};
    end else if (mag >= {2'b00, w}) begin
      r = '{kind: KIND_WARN, code: base, thr: w, conf: CONF_NOW};
    end
    if (sel == LAD_REGEN && !regen_en && mag >= {2'b00, REG_UNEXP_LVL} &&
        mag < {2'b00, REG_WARN}) begin
      r = '{kind: KIND_WARN, code: R_REG_UNEXP, thr: REG_UNEXP_LVL, conf: CONF_NOW};
    end
    return r;
  endfunction

endpackage

// ===== design/pack_overcurrent_fault_monitor.sv =====
// ----------------------------------------------------------------------------
// pack_overcurrent_fault_monitor
// Classifies pack current samples against mode-dependent threshold ladders,
// confirms and latches overcurrent trips, and tracks invalid sensor time.
// ----------------------------------------------------------------------------
//  channel   signals                                   role
//  sample    sample_valid/sample_ready + 6 fields      one current sample or clear
//  result    result_valid/result_ready + 9 fields      one status word per sample
//  config    psel/penable/pwrite/paddr/pwdata/prdata   APB register access
//
//  One word a cycle sustained while result_ready is high. Stage 1 registers
//  the accepted sample, stage 2 evaluates it against the monitor state and
//  raises result_valid; the state registers double as the result register.
//  A stalled result holds stage 2; stage 1 still takes one more word.
//  rst is synchronous: registers return to defaults, reason reads not ready.
// ----------------------------------------------------------------------------
module pack_overcurrent_fault_monitor #(
  parameter int MS_COUNTER_WIDTH = pofm_pkg::MS_COUNTER_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // sample channel
  input  logic               sample_valid,
  output logic               sample_ready,
  input  logic               cmd,
  input  logic [1:0]         op_mode,
  input  logic signed [16:0] pack_current,
  input  logic               sample_ok,
  input  logic [2:0]         sensor_status,
  input  logic [15:0]        elapsed_ms,
  // result channel
  output logic               result_valid,
  input  logic               result_ready,
  output logic               sensor_flag,
  output logic               warn_flag,
  output logic               pending_flag,
  output logic               confirmed_flag,
  output logic               latched_flag,
  output logic [4:0]         fault_reason,
  output logic [4:0]         latch_reason,
  output logic [14:0]        active_threshold,
  output logic [16:0]        current_magnitude,
  // config port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int W  = MS_COUNTER_WIDTH;
  localparam int CW = (W > 16) ? W : 16;
  localparam int SW = CW + 1;
  localparam logic [W-1:0] CNT_MAX = {W{1'b1}};

  // config registers
  logic        regen_enabled;
  logic [15:0] sensor_timeout_ms;
  logic [15:0] slow_confirm_ms;
  logic [15:0] fast_confirm_ms;
  logic [15:0] precharge_slow_ms;
  logic [15:0] precharge_fast_ms;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regen_enabled     <= 1'b0;
      sensor_timeout_ms <= pofm_pkg::SENSOR_MS_RST;
      slow_confirm_ms   <= pofm_pkg::SLOW_MS_RST;
      fast_confirm_ms   <= pofm_pkg::FAST_MS_RST;
      precharge_slow_ms <= pofm_pkg::PRE_SLOW_RST;
      precharge_fast_ms <= pofm_pkg::PRE_FAST_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[4:2])
        pofm_pkg::REG_REGEN_EN:  regen_enabled     <= pwdata[0];
        pofm_pkg::REG_SENSOR_MS: sensor_timeout_ms <= pwdata[15:0];
        pofm_pkg::REG_SLOW_MS:   slow_confirm_ms   <= pwdata[15:0];
        pofm_pkg::REG_FAST_MS:   fast_confirm_ms   <= pwdata[15:0];
        pofm_pkg::REG_PRE_SLOW:  precharge_slow_ms <= pwdata[15:0];
        pofm_pkg::REG_PRE_FAST:  precharge_fast_ms <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      pofm_pkg::REG_REGEN_EN:  prdata = {31'd0, regen_enabled};
      pofm_pkg::REG_SENSOR_MS: prdata = {16'd0, sensor_timeout_ms};
      pofm_pkg::REG_SLOW_MS:   prdata = {16'd0, slow_confirm_ms};
      pofm_pkg::REG_FAST_MS:   prdata = {16'd0, fast_confirm_ms};
      pofm_pkg::REG_PRE_SLOW:  prdata = {16'd0, precharge_slow_ms};
      pofm_pkg::REG_PRE_FAST:  prdata = {16'd0, precharge_fast_ms};
      default:                 prdata = 32'd0;
    endcase
  end

  // stage 1: input register
  logic        s1_valid;
  logic        s1_cmd;
  logic [1:0]  s1_mode;
  logic [16:0] s1_current;
  logic        s1_ok;
  logic [2:0]  s1_status;
  logic [15:0] s1_elapsed;
  logic        advance;

  assign advance      = s1_valid && (!result_valid || result_ready);
  assign sample_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample_ready) begin
      s1_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_ready && sample_valid) begin
      s1_cmd     <= cmd;
      s1_mode    <= op_mode;
      s1_current <= pack_current;
      s1_ok      <= sample_ok;
      s1_status  <= sensor_status;
      s1_elapsed <= elapsed_ms;
    end
  end

  // stage 2: evaluation against monitor state
  logic [W-1:0]  invalid_time;
  logic [4:0]    pending_code;
  logic [W-1:0]  pending_time;

  logic [W-1:0]  invalid_time_next;
  logic [4:0]    pending_code_next;
  logic [W-1:0]  pending_time_next;
  logic          sensor_flag_next;
  logic          warn_next;
  logic          pending_next;
  logic          confirmed_next;
  logic          latched_next;
  logic [4:0]    reason_next;
  logic [4:0]    latch_reason_next;
  logic [14:0]   threshold_next;
  logic [16:0]   magnitude_next;

  logic [16:0]           mag;
  logic [15:0]           dt;
  pofm_pkg::ladder_sel_t sel;
  pofm_pkg::ladder_t     lad;
  logic [15:0]           conf_ms;
  logic [W-1:0]          pend_base;
  logic [SW-1:0]         pend_sum;
  logic [SW-1:0]         inv_sum;
  logic [W-1:0]          pend_sat;
  logic [W-1:0]          inv_sat;

  always_comb begin
    mag = s1_current[16] ? (~s1_current + 17'd1) : s1_current;
    dt  = (s1_elapsed == 16'd0) ? 16'd1 : s1_elapsed;

    if (s1_mode == pofm_pkg::MODE_PRECHARGE) begin
      sel = pofm_pkg::LAD_PRECHARGE;
    end else if (!s1_current[16] && s1_current != 17'd0) begin
      sel = pofm_pkg::LAD_DISCHARGE;
    end else if (s1_mode == pofm_pkg::MODE_DRIVE) begin
      sel = pofm_pkg::LAD_REGEN;
    end else begin
      sel = pofm_pkg::LAD_CHARGE;
    end
    lad = pofm_pkg::run_ladder(mag, sel, regen_enabled);

    unique case (lad.conf)
      pofm_pkg::CONF_SLOW:     conf_ms = slow_confirm_ms;
      pofm_pkg::CONF_FAST:     conf_ms = fast_confirm_ms;
      pofm_pkg::CONF_PRE_SLOW: conf_ms = precharge_slow_ms;
      pofm_pkg::CONF_PRE_FAST: conf_ms = precharge_fast_ms;
      default:                 conf_ms = 16'd0;
    endcase

    pend_base = (pending_code != lad.code) ? '0 : pending_time;
    pend_sum  = SW'(pend_base) + SW'(dt);
    pend_sat  = (pend_sum > SW'(CNT_MAX)) ? CNT_MAX : pend_sum[W-1:0];
    inv_sum   = SW'(invalid_time) + SW'(dt);
    inv_sat   = (inv_sum > SW'(CNT_MAX)) ? CNT_MAX : inv_sum[W-1:0];

    invalid_time_next = invalid_time;
    pending_code_next = pending_code;
    pending_time_next = pending_time;
    sensor_flag_next  = sensor_flag;
    warn_next         = warn_flag;
    pending_next      = pending_flag;
    confirmed_next    = confirmed_flag;
    latched_next      = latched_flag;
    reason_next       = fault_reason;
    latch_reason_next = latch_reason;
    threshold_next    = active_threshold;
    magnitude_next    = mag;

    if (s1_cmd == pofm_pkg::CMD_CLEAR) begin
      latched_next      = 1'b0;
      latch_reason_next = pofm_pkg::R_NONE;
      if (confirmed_flag) begin
        confirmed_next = 1'b0;
        reason_next    = pofm_pkg::R_NONE;
      end
      magnitude_next = 17'd0;
    end else if (!s1_ok) begin
      invalid_time_next = inv_sat;
      warn_next         = 1'b0;
      pending_next      = 1'b0;
      confirmed_next    = 1'b0;
      pending_code_next = pofm_pkg::R_NONE;
      pending_time_next = '0;
      threshold_next    = 15'd0;
      reason_next       = pofm_pkg::sensor_code(s1_status);
      if (CW'(inv_sat) >= CW'(sensor_timeout_ms)) begin
        sensor_flag_next = 1'b1;
      end
    end else begin
      invalid_time_next = '0;
      sensor_flag_next  = 1'b0;
      unique case (lad.kind)
        pofm_pkg::KIND_WARN: begin
          threshold_next    = lad.thr;
          warn_next         = 1'b1;
          pending_next      = 1'b0;
          confirmed_next    = 1'b0;
          pending_time_next = '0;
          pending_code_next = pofm_pkg::R_NONE;
          reason_next       = lad.code;
        end
        pofm_pkg::KIND_TRIP: begin
          threshold_next    = lad.thr;
          warn_next         = 1'b0;
          pending_next      = 1'b1;
          pending_code_next = lad.code;
          pending_time_next = pend_sat;
          reason_next       = lad.code;
          if (CW'(pend_sat) >= CW'(conf_ms)) begin
            pending_next      = 1'b0;
            confirmed_next    = 1'b1;
            latched_next      = 1'b1;
            latch_reason_next = lad.code;
          end
        end
        default: begin
          warn_next         = 1'b0;
          pending_next      = 1'b0;
          confirmed_next    = 1'b0;
          reason_next       = pofm_pkg::R_NONE;
          pending_code_next = pofm_pkg::R_NONE;
          pending_time_next = '0;
          threshold_next    = 15'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid     <= 1'b0;
      invalid_time     <= '0;
      pending_code     <= pofm_pkg::R_NONE;
      pending_time     <= '0;
      sensor_flag      <= 1'b0;
      warn_flag        <= 1'b0;
      pending_flag     <= 1'b0;
      confirmed_flag   <= 1'b0;
      latched_flag     <= 1'b0;
      fault_reason     <= pofm_pkg::R_NOT_READY;
      latch_reason     <= pofm_pkg::R_NONE;
      active_threshold <= 15'd0;
    end else if (advance) begin
      result_valid     <= 1'b1;
      invalid_time     <= invalid_time_next;
      pending_code     <= pending_code_next;
      pending_time     <= pending_time_next;
      sensor_flag      <= sensor_flag_next;
      warn_flag        <= warn_next;
      pending_flag     <= pending_next;
      confirmed_flag   <= confirmed_next;
      latched_flag     <= latched_next;
      fault_reason     <= reason_next;
      latch_reason     <= latch_reason_next;
      active_threshold <= threshold_next;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      current_magnitude <= magnitude_next;
    end
  end

endmodule

// ===== design/pofm_chk.sv =====
// ----------------------------------------------------------------------------
// pofm_chk
// Port-level checks of the pack overcurrent monitor, bound to the top level.
// ----------------------------------------------------------------------------
module pofm_chk (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_ready,
  input logic        sensor_flag,
  input logic        warn_flag,
  input logic        pending_flag,
  input logic        confirmed_flag,
  input logic        latched_flag,
  input logic [4:0]  fault_reason,
  input logic [4:0]  latch_reason,
  input logic [14:0] active_threshold
);

  a_no_result_after_reset: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result word right after reset");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("stalled result word dropped");

  a_latch_has_reason: assert property (@(posedge clk) disable iff (rst)
    result_valid && latched_flag |-> latch_reason != pofm_pkg::R_NONE)
    else $error("latched trip without reason");

  // a confirmed trip may sit beside a newer pending trip; a warning never does
  a_status_exclusive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(warn_flag && (pending_flag || confirmed_flag)))
    else $error("warning overlaps pending or confirmed");

  a_sensor_flag_quiet: assert property (@(posedge clk) disable iff (rst)
    result_valid && sensor_flag |-> active_threshold == 15'd0 &&
      fault_reason != pofm_pkg::R_NONE && fault_reason <= pofm_pkg::R_MISMATCH)
    else $error("sensor fault with current trip status");

endmodule

bind pack_overcurrent_fault_monitor pofm_chk u_pofm_chk (
  .clk              (clk),
  .rst              (rst),
  .result_valid     (result_valid),
  .result_ready     (result_ready),
  .sensor_flag      (sensor_flag),
  .warn_flag        (warn_flag),
  .pending_flag     (pending_flag),
  .confirmed_flag   (confirmed_flag),
  .latched_flag     (latched_flag),
  .fault_reason     (fault_reason),
  .latch_reason     (latch_reason),
  .active_threshold (active_threshold)
);

// ===== tb/sv/pack_overcurrent_fault_monitor_tb.sv =====
// ----------------------------------------------------------------------------
// pack_overcurrent_fault_monitor_tb
// Self-checking bench for the pack overcurrent monitor. A short directed table
// walks the ladder extremes, the sensor status codes and the clear command.
// Random bursts of trip, warning, invalid and clear words follow, under six
// register settings that include the all-zero and all-ones confirm times.
// Each result word is checked against a behavioral model of the monitor state,
// or against a fixed word for typed rows, with random stalls on both channels.
// ----------------------------------------------------------------------------
module pack_overcurrent_fault_monitor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RANDOM_PER_SET = 230;
  localparam int NUM_SETS       = 6;

  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_NULL     = 3'd1;
  localparam logic [2:0] STAT_UNMAPPED = 3'd2;
  localparam logic [2:0] STAT_UNDEF    = 3'd7;

  localparam logic [4:0] R_DIS_EXT = pofm_pkg::R_DIS_BASE + 5'd3;
  localparam logic [4:0] R_CHG_EXT = pofm_pkg::R_CHG_BASE + 5'd3;

  localparam logic [2:0] REG_ORDER [6] = '{pofm_pkg::REG_REGEN_EN, pofm_pkg::REG_SENSOR_MS,
                                           pofm_pkg::REG_SLOW_MS, pofm_pkg::REG_FAST_MS,
                                           pofm_pkg::REG_PRE_SLOW, pofm_pkg::REG_PRE_FAST};
  localparam int LEVELS [15] = '{80, 120, 200, 500, 1050, 1200, 1500, 2000, 2500,
                                 3000, 5000, 7000, 8500, 12000, 24000};

  typedef struct packed {
    logic               cmd;
    logic [1:0]         mode;
    logic signed [16:0] cur;
    logic               ok;
    logic [2:0]         status;
    logic [15:0]        dt;
  } sample_t;

  typedef struct packed {
    logic        sf;
    logic        warn;
    logic        pend;
    logic        conf;
    logic        latch;
    logic [4:0]  reason;
    logic [4:0]  lreason;
    logic [14:0] thr;
    logic [16:0] mag;
  } verdict_t;

  typedef struct {
    pofm_pkg::level_kind_t kind;
    logic [4:0]            code;
    logic [14:0]           thr;
    int unsigned           hold_ms;
  } grade_t;

  typedef struct {
    sample_t  s;
    logic     typed;
    verdict_t want;
  } plan_row_t;

  logic               clk;
  logic               rst;
  logic               sample_valid;
  logic               sample_ready;
  logic               cmd;
  logic [1:0]         op_mode;
  logic signed [16:0] pack_current;
  logic               sample_ok;
  logic [2:0]         sensor_status;
  logic [15:0]        elapsed_ms;
  logic               result_valid;
  logic               result_ready = 1'b0;
  logic               sensor_flag;
  logic               warn_flag;
  logic               pending_flag;
  logic               confirmed_flag;
  logic               latched_flag;
  logic [4:0]         fault_reason;
  logic [4:0]         latch_reason;
  logic [14:0]        active_threshold;
  logic [16:0]        current_magnitude;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [4:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  // monitor model state
  logic [15:0] cfg_val [6];
  logic [15:0] inv_ms;
  logic [15:0] pend_ms;
  logic        sf_st;
  logic        warn_st;
  logic        pend_st;
  logic        conf_st;
  logic        latch_st;
  logic [4:0]  reason_st;
  logic [4:0]  pend_code_st;
  logic [4:0]  latch_code_st;
  logic [14:0] thr_st;

  verdict_t verdict_q [$];
  plan_row_t plan [$];
  int mismatches = 0;
  int words_sent = 0;
  int trips_confirmed = 0;
  int clears_sent = 0;
  int stall_cycles = 0;
  int src_idle_pct = 30;
  int dst_idle_pct = 58;

  pack_overcurrent_fault_monitor u_top (
    .clk               (clk),
    .rst               (rst),
    .sample_valid      (sample_valid),
    .sample_ready      (sample_ready),
    .cmd               (cmd),
    .op_mode           (op_mode),
    .pack_current      (pack_current),
    .sample_ok         (sample_ok),
    .sensor_status     (sensor_status),
    .elapsed_ms        (elapsed_ms),
    .result_valid      (result_valid),
    .result_ready      (result_ready),
    .sensor_flag       (sensor_flag),
    .warn_flag         (warn_flag),
    .pending_flag      (pending_flag),
    .confirmed_flag    (confirmed_flag),
    .latched_flag      (latched_flag),
    .fault_reason      (fault_reason),
    .latch_reason      (latch_reason),
    .active_threshold  (active_threshold),
    .current_magnitude (current_magnitude),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [15:0] sat_ms(input logic [15:0] a, input int unsigned b);
    int unsigned s;
    s = a + b;
    return (s > 32'hFFFF) ? 16'hFFFF : s[15:0];
  endfunction

  function automatic grade_t grade(input logic [16:0] mag, input pofm_pkg::ladder_sel_t lad);
    logic [14:0] lv [4];
    logic [4:0]  base;
    int unsigned slow_t;
    int unsigned fast_t;
    grade_t      g;
    g.kind = pofm_pkg::KIND_NONE;
    g.code = pofm_pkg::R_NONE;
    g.thr = '0;
    g.hold_ms = 0;
    slow_t = cfg_val[pofm_pkg::REG_SLOW_MS];
    fast_t = cfg_val[pofm_pkg::REG_FAST_MS];
    case (lad)
      pofm_pkg::LAD_DISCHARGE: begin
        lv = '{pofm_pkg::DIS_WARN, pofm_pkg::DIS_TRIP, pofm_pkg::DIS_FAST,
               pofm_pkg::DIS_EXT};
        base = pofm_pkg::R_DIS_BASE;
      end
      pofm_pkg::LAD_CHARGE: begin
        lv = '{pofm_pkg::CHG_WARN, pofm_pkg::CHG_TRIP, pofm_pkg::CHG_FAST,
               pofm_pkg::CHG_EXT};
        base = pofm_pkg::R_CHG_BASE;
      end
      pofm_pkg::LAD_REGEN: begin
        lv = '{pofm_pkg::REG_WARN, pofm_pkg::REG_TRIP, pofm_pkg::REG_FAST,
               pofm_pkg::REG_EXT};
        base = pofm_pkg::R_REG_BASE;
      end
      default: begin
        lv = '{pofm_pkg::PRE_WARN, pofm_pkg::PRE_TRIP, pofm_pkg::PRE_FAST, 15'd0};
        base = pofm_pkg::R_PRE_BASE;
        slow_t = cfg_val[pofm_pkg::REG_PRE_SLOW];
        fast_t = cfg_val[pofm_pkg::REG_PRE_FAST];
      end
    endcase
    // top rung first; a zero rung does not exist
    for (int i = 3; i >= 0; i--) begin
      if (g.kind == pofm_pkg::KIND_NONE && lv[i] != 15'd0 && mag >= {2'b00, lv[i]}) begin
        g.kind = (i == 0) ? pofm_pkg::KIND_WARN : pofm_pkg::KIND_TRIP;
        g.code = base + 5'(i);
        g.thr = lv[i];
        g.hold_ms = (i == 2) ? fast_t : (i == 1) ? slow_t : 0;
      end
    end
    if (lad == pofm_pkg::LAD_REGEN && !cfg_val[pofm_pkg::REG_REGEN_EN][0] &&
        mag >= {2'b00, pofm_pkg::REG_UNEXP_LVL} && mag < {2'b00, pofm_pkg::REG_WARN}) begin
      g.kind = pofm_pkg::KIND_WARN;
      g.code = pofm_pkg::R_REG_UNEXP;
      g.thr = pofm_pkg::REG_UNEXP_LVL;
      g.hold_ms = 0;
    end
    return g;
  endfunction

  task automatic monitor_step(input sample_t s, output verdict_t v);
    int                    cur_i;
    logic [16:0]           mag;
    logic [16:0]           shown;
    int unsigned           step;
    pofm_pkg::ladder_sel_t lad;
    grade_t                g;
    cur_i = int'($signed(s.cur));
    mag = (cur_i < 0) ? 17'(-cur_i) : 17'(cur_i);
    shown = mag;
    step = (s.dt == 16'd0) ? 1 : s.dt;
    if (s.cmd == pofm_pkg::CMD_CLEAR) begin
      clears_sent++;
      latch_st = 1'b0;
      latch_code_st = pofm_pkg::R_NONE;
      if (conf_st) begin
        conf_st = 1'b0;
        reason_st = pofm_pkg::R_NONE;
      end
      shown = '0;
    end else if (!s.ok) begin
      inv_ms = sat_ms(inv_ms, step);
      warn_st = 1'b0;
      pend_st = 1'b0;
      conf_st = 1'b0;
      pend_code_st = pofm_pkg::R_NONE;
      pend_ms = '0;
      thr_st = '0;
      case (s.status)
        pofm_pkg::STAT_ADC_READ:   reason_st = pofm_pkg::R_ADC_READ;
        pofm_pkg::STAT_IMPLAUS:    reason_st = pofm_pkg::R_IMPLAUS;
        pofm_pkg::STAT_SATURATION: reason_st = pofm_pkg::R_SATURATION;
        pofm_pkg::STAT_MISMATCH:   reason_st = pofm_pkg::R_MISMATCH;
        default:                   reason_st = pofm_pkg::R_NOT_READY;
      endcase
      if (inv_ms >= cfg_val[pofm_pkg::REG_SENSOR_MS]) sf_st = 1'b1;
    end else begin
      inv_ms = '0;
      sf_st = 1'b0;
      if (s.mode == pofm_pkg::MODE_PRECHARGE) lad = pofm_pkg::LAD_PRECHARGE;
      else if (cur_i > 0) lad = pofm_pkg::LAD_DISCHARGE;
      else if (s.mode == pofm_pkg::MODE_DRIVE) lad = pofm_pkg::LAD_REGEN;
      else lad = pofm_pkg::LAD_CHARGE;
      g = grade(mag, lad);
      case (g.kind)
        pofm_pkg::KIND_NONE: begin
          warn_st = 1'b0;
          pend_st = 1'b0;
          conf_st = 1'b0;
          reason_st = pofm_pkg::R_NONE;
          pend_code_st = pofm_pkg::R_NONE;
          pend_ms = '0;
          thr_st = '0;
        end
        pofm_pkg::KIND_WARN: begin
          thr_st = g.thr;
          warn_st = 1'b1;
          pend_st = 1'b0;
          conf_st = 1'b0;
          pend_ms = '0;
          pend_code_st = pofm_pkg::R_NONE;
          reason_st = g.code;
        end
        default: begin
          thr_st = g.thr;
          warn_st = 1'b0;
          pend_st = 1'b1;
          if (pend_code_st != g.code) begin
            pend_code_st = g.code;
            pend_ms = '0;
          end
          pend_ms = sat_ms(pend_ms, step);
          reason_st = g.code;
          if (g.hold_ms == 0 || pend_ms >= g.hold_ms) begin
            pend_st = 1'b0;
            conf_st = 1'b1;
            latch_st = 1'b1;
            latch_code_st = g.code;
            trips_confirmed++;
          end
        end
      endcase
    end
    v = '{sf_st, warn_st, pend_st, conf_st, latch_st, reason_st, latch_code_st, thr_st,
          shown};
  endtask

  function automatic sample_t mk(input logic c, input logic [1:0] m, input int cur,
                                 input logic ok, input logic [2:0] st, input logic [15:0] dt);
    return '{c, m, 17'(cur), ok, st, dt};
  endfunction

  task automatic cmp_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // result checker
  always @(posedge clk) begin : result_check
    verdict_t want;
    if (!rst && result_valid && result_ready) begin
      if (verdict_q.size() == 0) begin
        mismatches++;
        $display("%0t: result word with nothing expected, reason %0d", $time, fault_reason);
      end else begin
        want = verdict_q.pop_front();
        cmp_field("sensor_flag", want.sf, sensor_flag);
        cmp_field("warn_flag", want.warn, warn_flag);
        cmp_field("pending_flag", want.pend, pending_flag);
        cmp_field("confirmed_flag", want.conf, confirmed_flag);
        cmp_field("latched_flag", want.latch, latched_flag);
        cmp_field("fault_reason", want.reason, fault_reason);
        cmp_field("latch_reason", want.lreason, latch_reason);
        cmp_field("active_threshold", want.thr, active_threshold);
        cmp_field("current_magnitude", want.mag, current_magnitude);
      end
    end
  end

  always @(negedge clk) begin
    result_ready <= ($urandom_range(99) >= dst_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (sample_valid && sample_ready) || (result_valid && result_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("[pack_overcurrent_fault_monitor] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_word(input sample_t s, input logic typed, input verdict_t want);
    verdict_t v;
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    sample_valid  <= 1'b1;
    cmd           <= s.cmd;
    op_mode       <= s.mode;
    pack_current  <= s.cur;
    sample_ok     <= s.ok;
    sensor_status <= s.status;
    elapsed_ms    <= s.dt;
    do @(posedge clk); while (!sample_ready);
    monitor_step(s, v);
    verdict_q.push_back(typed ? want : v);
    words_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    sample_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_access(input logic [2:0] idx, input logic wr, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wr ? data : 32'd0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (!wr && prdata != data) begin
      mismatches++;
      $display("%0t: register %0d readback, expected %0d, actual %0d", $time, idx, data,
               prdata);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_settings();
    foreach (REG_ORDER[i]) cfg_access(REG_ORDER[i], 1'b0, {16'd0, cfg_val[REG_ORDER[i]]});
  endtask

  task automatic load_settings(input logic [5:0][15:0] vals);
    logic [2:0]  idx;
    logic [31:0] data;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    foreach (REG_ORDER[i]) begin
      idx = REG_ORDER[i];
      data = (idx == pofm_pkg::REG_REGEN_EN) ? {31'd0, vals[idx][0]} :
                                                {16'd0, vals[idx]};
      cfg_access(idx, 1'b1, data);
      cfg_val[idx] = data[15:0];
    end
    check_settings();
  endtask

  function automatic logic [5:0][15:0] make_settings(input logic regen, input logic [15:0] sens,
      input logic [15:0] slow, input logic [15:0] fast, input logic [15:0] pslow,
      input logic [15:0] pfast);
    logic [5:0][15:0] v;
    v = '0;
    v[pofm_pkg::REG_REGEN_EN]  = {15'd0, regen};
    v[pofm_pkg::REG_SENSOR_MS] = sens;
    v[pofm_pkg::REG_SLOW_MS]   = slow;
    v[pofm_pkg::REG_FAST_MS]   = fast;
    v[pofm_pkg::REG_PRE_SLOW]  = pslow;
    v[pofm_pkg::REG_PRE_FAST]  = pfast;
    return v;
  endfunction

  function automatic logic [15:0] rand_dt();
    case ($urandom_range(9))
      0:       return 16'($urandom);
      1:       return 16'd0;
      2:       return 16'($urandom_range(0, 1000));
      default: return 16'($urandom_range(0, 120));
    endcase
  endfunction

  function automatic int near_level();
    int v;
    v = LEVELS[$urandom_range(14)] + int'($urandom_range(0, 6)) - 3;
    return $urandom_range(1) ? v : -v;
  endfunction

  task automatic random_bursts(input int target);
    int        sent;
    int        sel;
    int        len;
    int        lvl;
    logic [1:0] m;
    sent = 0;
    while (sent < target) begin
      sel = $urandom_range(99);
      m = 2'($urandom_range(3));
      if ($urandom_range(39) == 0) wait_drained();
      if (sel < 55) begin
        // same level for a run of words so trips get to confirm
        lvl = near_level();
        len = $urandom_range(2, 10);
        for (int j = 0; j < len; j++) begin
          send_word(mk(pofm_pkg::CMD_EVAL, m, lvl + int'($urandom_range(0, 4)) - 2, 1'b1,
                       STAT_OK, rand_dt()), 1'b0, '0);
        end
        sent += len;
      end else if (sel < 70) begin
        len = $urandom_range(1, 6);
        for (int j = 0; j < len; j++) begin
          send_word(mk(pofm_pkg::CMD_EVAL, m, int'($urandom), 1'b0, 3'($urandom_range(7)),
                       rand_dt()), 1'b0, '0);
        end
        sent += len;
      end else if (sel < 80) begin
        send_word(mk(pofm_pkg::CMD_CLEAR, m, int'($urandom), 1'($urandom),
                     3'($urandom_range(7)), 16'($urandom)), 1'b0, '0);
        sent++;
      end else begin
        send_word(mk(($urandom_range(9) == 0) ? pofm_pkg::CMD_CLEAR : pofm_pkg::CMD_EVAL, m,
                     int'($urandom), 1'($urandom), 3'($urandom_range(7)), 16'($urandom)),
                  1'b0, '0);
        sent++;
      end
    end
  endtask

  initial begin
    logic [5:0][15:0] setting;
    rst           <= 1'b1;
    sample_valid  <= 1'b0;
    cmd           <= pofm_pkg::CMD_EVAL;
    op_mode       <= pofm_pkg::MODE_IDLE;
    pack_current  <= '0;
    sample_ok     <= 1'b0;
    sensor_status <= STAT_OK;
    elapsed_ms    <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    cfg_val[pofm_pkg::REG_REGEN_EN]  = 16'd0;
    cfg_val[pofm_pkg::REG_SENSOR_MS] = pofm_pkg::SENSOR_MS_RST;
    cfg_val[pofm_pkg::REG_SLOW_MS]   = pofm_pkg::SLOW_MS_RST;
    cfg_val[pofm_pkg::REG_FAST_MS]   = pofm_pkg::FAST_MS_RST;
    cfg_val[pofm_pkg::REG_PRE_SLOW]  = pofm_pkg::PRE_SLOW_RST;
    cfg_val[pofm_pkg::REG_PRE_FAST]  = pofm_pkg::PRE_FAST_RST;
    inv_ms = '0;
    pend_ms = '0;
    sf_st = 1'b0;
    warn_st = 1'b0;
    pend_st = 1'b0;
    conf_st = 1'b0;
    latch_st = 1'b0;
    reason_st = pofm_pkg::R_NOT_READY;
    pend_code_st = pofm_pkg::R_NONE;
    latch_code_st = pofm_pkg::R_NONE;
    thr_st = '0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    check_settings();

    plan.push_back('{mk(pofm_pkg::CMD_CLEAR, pofm_pkg::MODE_IDLE, 0, 1'b1, STAT_OK, 16'd0),
                     1'b1, verdict_t'{0, 0, 0, 0, 0, pofm_pkg::R_NOT_READY, pofm_pkg::R_NONE,
                                      0, 0}});
    plan.push_back('{mk(pofm_pkg::CMD_EVAL, pofm_pkg::MODE_DRIVE, 0, 1'b1, STAT_OK, 16'd0),
                     1'b1, verdict_t'{0, 0, 0, 0, 0, pofm_pkg::R_NONE, pofm_pkg::R_NONE,
                                      0, 0}});
    plan.push_back('{mk(pofm_pkg::CMD_EVAL, pofm_pkg::MODE_DRIVE, 24000, 1'b1, STAT_OK, 16'd1),
                     1'b1, verdict_t'{0, 0, 0, 1, 1, R_DIS_EXT, R_DIS_EXT, pofm_pkg::DIS_EXT,
                                      24000}});
    plan.push_back('{mk(pofm_pkg::CMD_EVAL, pofm_pkg::MODE_IDLE, 65535, 1'b1, STAT_OK,
                        16'hFFFF),
                     1'b1, verdict_t'{0, 0, 0, 1, 1, R_DIS_EXT, R_DIS_EXT, pofm_pkg::DIS_EXT,
                                      65535}});
    plan.push_back('{mk(pofm_pkg::CMD_EVAL, pofm_pkg::MODE_CHARGE, -65536, 1'b1, STAT_OK,
                        16'd1),
                     1'b1, verdict_t'{0, 0, 0, 1, 1, R_CHG_EXT, R_CHG_EXT, pofm_pkg::CHG_EXT,
                                      65536}});
    plan.push_back('{mk(pofm_pkg::CMD_CLEAR, pofm_pkg::MODE_PRECHARGE, -1, 1'b0, STAT_UNDEF,
                        16'hFFFF),
                     1'b1, verdict_t'{0, 0, 0, 0, 0, pofm_pkg::R_NONE, pofm_pkg::R_NONE,
                                      pofm_pkg::CHG_EXT, 0}});
    plan.push_back('{mk(pofm_pkg::CMD_EVAL, pofm_pkg::MODE_DRIVE, 100, 1'b0,
                        pofm_pkg::STAT_ADC_READ, 16'd0),
                     1'b1, verdict_t'{0, 0, 0, 0, 0, pofm_pkg::R_ADC_READ, pofm_pkg::R_NONE,
                                      0, 100}});
    plan.push_back('{mk(pofm_pkg::CMD_EVAL, pofm_pkg::MODE_DRIVE, -100, 1'b0,
                        pofm_pkg::STAT_IMPLAUS, 16'hFFFF),
                     1'b1, verdict_t'{1, 0, 0, 0, 0, pofm_pkg::R_IMPLAUS, pofm_pkg::R_NONE,
                                      0, 100}});
    plan.push_back('{mk(pofm_pkg::CMD_EVAL, pofm_pkg::MODE_CHARGE, 0, 1'b0,
                        pofm_pkg::STAT_SATURATION, 16'd1),
                     1'b1, verdict_t'{1, 0, 0, 0, 0, pofm_pkg::R_SATURATION, pofm_pkg::R_NONE,
                                      0, 0}});
    plan.push_back('{mk(pofm_pkg::CMD_EVAL, pofm_pkg::MODE_PRECHARGE, 65535, 1'b0,
                        pofm_pkg::STAT_MISMATCH, 16'd1),
                     1'b1, verdict_t'{1, 0, 0, 0, 0, pofm_pkg::R_MISMATCH, pofm_pkg::R_NONE,
                                      0, 65535}});
    plan.push_back('{mk(pofm_pkg::CMD_EVAL, pofm_pkg::MODE_IDLE, -65536, 1'b0, STAT_UNDEF,
                        16'd1),
                     1'b1, verdict_t'{1, 0, 0, 0, 0, pofm_pkg::R_NOT_READY, pofm_pkg::R_NONE,
                                      0, 65536}});
    plan.push_back('{mk(pofm_pkg::CMD_EVAL, pofm_pkg::MODE_IDLE, 0, 1'b0, STAT_NULL, 16'd1),
                     1'b0, '0});
    plan.push_back('{mk(pofm_pkg::CMD_EVAL, pofm_pkg::MODE_IDLE, 0, 1'b1, STAT_UNMAPPED,
                        16'd1),
                     1'b1, verdict_t'{0, 0, 0, 0, 0, pofm_pkg::R_NONE, pofm_pkg::R_NONE,
                                      0, 0}});
    plan.push_back('{mk(pofm_pkg::CMD_EVAL, pofm_pkg::MODE_DRIVE, -500, 1'b1, STAT_OK, 16'd1),
                     1'b0, '0});
    plan.push_back('{mk(pofm_pkg::CMD_EVAL, pofm_pkg::MODE_DRIVE, -2000, 1'b1, STAT_OK, 16'd1),
                     1'b0, '0});
    plan.push_back('{mk(pofm_pkg::CMD_EVAL, pofm_pkg::MODE_DRIVE, -2500, 1'b1, STAT_OK,
                        16'd300), 1'b0, '0});
    plan.push_back('{mk(pofm_pkg::CMD_EVAL, pofm_pkg::MODE_DRIVE, -2600, 1'b1, STAT_OK,
                        16'd250), 1'b0, '0});
    plan.push_back('{mk(pofm_pkg::CMD_EVAL, pofm_pkg::MODE_DRIVE, -3000, 1'b1, STAT_OK,
                        16'd50), 1'b0, '0});
    plan.push_back('{mk(pofm_pkg::CMD_EVAL, pofm_pkg::MODE_DRIVE, -5000, 1'b1, STAT_OK, 16'd1),
                     1'b0, '0});
    plan.push_back('{mk(pofm_pkg::CMD_EVAL, pofm_pkg::MODE_CHARGE, -1050, 1'b1, STAT_OK,
                        16'd1), 1'b0, '0});
    plan.push_back('{mk(pofm_pkg::CMD_EVAL, pofm_pkg::MODE_IDLE, -1200, 1'b1, STAT_OK,
                        16'd499), 1'b0, '0});
    plan.push_back('{mk(pofm_pkg::CMD_EVAL, pofm_pkg::MODE_CHARGE, -1500, 1'b1, STAT_OK,
                        16'd100), 1'b0, '0});
    plan.push_back('{mk(pofm_pkg::CMD_EVAL, pofm_pkg::MODE_DRIVE, 8500, 1'b1, STAT_OK,
                        16'd500), 1'b0, '0});
    plan.push_back('{mk(pofm_pkg::CMD_EVAL, pofm_pkg::MODE_DRIVE, 12000, 1'b1, STAT_OK,
                        16'd99), 1'b0, '0});
    plan.push_back('{mk(pofm_pkg::CMD_EVAL, pofm_pkg::MODE_PRECHARGE, 80, 1'b1, STAT_OK,
                        16'd1), 1'b0, '0});
    plan.push_back('{mk(pofm_pkg::CMD_EVAL, pofm_pkg::MODE_PRECHARGE, -120, 1'b1, STAT_OK,
                        16'd200), 1'b0, '0});
    plan.push_back('{mk(pofm_pkg::CMD_EVAL, pofm_pkg::MODE_PRECHARGE, 200, 1'b1, STAT_OK,
                        16'd39), 1'b0, '0});
    plan.push_back('{mk(pofm_pkg::CMD_CLEAR, pofm_pkg::MODE_DRIVE, 0, 1'b1, STAT_OK, 16'd0),
                     1'b0, '0});
    foreach (plan[i]) send_word(plan[i].s, plan[i].typed, plan[i].want);

    for (int k = 0; k < NUM_SETS; k++) begin
      case (k)
        0: setting = make_settings(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        1: setting = make_settings(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: setting = make_settings(1'($urandom), 16'($urandom_range(1, 700)),
                                   16'($urandom_range(1, 700)), 16'($urandom_range(1, 700)),
                                   16'($urandom_range(1, 700)), 16'($urandom_range(1, 700)));
        3: setting = make_settings(1'b1, 16'd500, 16'd500, 16'd100, 16'd200, 16'd40);
        4: setting = make_settings(1'($urandom), 16'($urandom_range(0, 300)),
                                   16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)),
                                   16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)));
        default: setting = make_settings(1'b0, 16'd30, 16'd300, 16'd60, 16'd120, 16'd20);
      endcase
      load_settings(setting);
      src_idle_pct = (k < 2) ? 30 : (k < 4) ? 58 : 0;
      dst_idle_pct = (k < 2) ? 58 : (k < 4) ? 30 : 0;
      random_bursts(RANDOM_PER_SET);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d sample words under %0d register settings plus reset defaults;",
             words_sent, NUM_SETS);
    $display("  %0d trips confirmed by the model, %0d clear words.", trips_confirmed,
             clears_sent);
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("[pack_overcurrent_fault_monitor] OK");
    end else begin
      $display("[pack_overcurrent_fault_monitor] ERROR");
    end
    $finish;
  end

endmodule
